// File: rtl/core/pcshp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcshp_pkg: shared types and constants of the pc sampling profiler
// Table sizes, beat layouts, request kinds, answer codes and sequencer states.
// ----------------------------------------------------------------------------
package pcshp_pkg;

  // table sizing
  localparam int TABLE_DEPTH = 2048;
  localparam int MIN_SYMBOLS = 3;
  localparam int SYM_AW      = $clog2(TABLE_DEPTH);
  localparam int CNT_DEPTH   = TABLE_DEPTH + 1;
  localparam int CNT_AW      = $clog2(CNT_DEPTH);

  // field widths
  localparam int COUNT_W = 12;
  localparam int DATA_W  = 32;
  localparam int KIND_W  = 3;

  // input tdata layout, lowest bit first
  localparam int LCNT_LSB = 0;
  localparam int SVAL_LSB = LCNT_LSB + COUNT_W;
  localparam int SPC_LSB  = SVAL_LSB + DATA_W;
  localparam int USER_BIT = SPC_LSB + DATA_W;
  localparam int EN_BIT   = USER_BIT + 1;
  localparam int RIDX_LSB = EN_BIT + 1;
  localparam int IN_BITS  = RIDX_LSB + COUNT_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = DATA_W;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    ACT_LOAD_START   = 3'd0,
    ACT_LOAD_SYMBOL  = 3'd1,
    ACT_SAMPLE       = 3'd2,
    ACT_SET_ENABLE   = 3'd3,
    ACT_READ_STATUS  = 3'd4,
    ACT_READ_COUNT   = 3'd5,
    ACT_READ_SYMBOL  = 3'd6,
    ACT_READ_COUNTER = 3'd7
  } action_t;

  // answer codes
  typedef enum logic [KIND_W-1:0] {
    ERR_OK          = 3'd0,
    ERR_NOT_LOADED  = 3'd1,
    ERR_BUSY        = 3'd2,
    ERR_NO_SPACE    = 3'd3,
    ERR_TOO_SHORT   = 3'd4,
    ERR_UNSORTED    = 3'd5,
    ERR_BAD_REQUEST = 3'd6
  } err_t;

  // sequencer states
  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_SRCH    = 8'b0000_0100,
    S_CMP     = 8'b0000_1000,
    S_CNT_RD  = 8'b0001_0000,
    S_CNT_WR  = 8'b0010_0000,
    S_RD_WAIT = 8'b0100_0000,
    S_RESP    = 8'b1000_0000
  } state_t;

endpackage

// File: rtl/core/pc_sample_histogram_profiler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_sample_histogram_profiler_unit: pc sampling profiler
// Loads a sorted symbol table, bins kernel samples by binary search into a
// histogram of 32-bit hit counters, and serves status and table readback.
//
//  channel | dir | tdata                        | tuser
//  in_     | in  | request fields (see port)    | action
//  out_    | out | read_data                    | error_code
//
//  a kernel sample runs search steps of S_SRCH then S_CMP, then answers
//  through S_CNT_RD, S_CNT_WR and S_RESP; the single symbol ram read port
//  and the one pc compare are reused on every step
//  a user sample goes through S_CNT_RD, S_CNT_WR and S_RESP, a readback
//  through S_RD_WAIT and S_RESP, other requests straight to S_RESP; an
//  accepted load_start also sweeps the counter ram, one entry a cycle,
//  over all 2049 entries, before it answers
//  after reset the same sweep runs before in_tready rises
//  a stalled result waits in the output register while the next beat is taken
// ----------------------------------------------------------------------------
module pc_sample_histogram_profiler_unit
  import pcshp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // load_count[11:0], symbol_value[43:12], sample_pc[75:44], user_mode[76],
  // enable_request[77], read_index[89:78], zero fill above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action[2:0]
  input  logic [KIND_W-1:0]      in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // read_data[31:0]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // error_code[2:0]
  output logic [KIND_W-1:0]      out_tuser
);

  // input beat fields
  logic [COUNT_W-1:0] load_count;
  logic [DATA_W-1:0]  symbol_value;
  logic [DATA_W-1:0]  sample_pc;
  logic               user_mode;
  logic               enable_request;
  logic [COUNT_W-1:0] read_index;
  action_t            action;

  assign load_count     = in_tdata[LCNT_LSB +: COUNT_W];
  assign symbol_value   = in_tdata[SVAL_LSB +: DATA_W];
  assign sample_pc      = in_tdata[SPC_LSB +: DATA_W];
  assign user_mode      = in_tdata[USER_BIT];
  assign enable_request = in_tdata[EN_BIT];
  assign read_index     = in_tdata[RIDX_LSB +: COUNT_W];
  assign action         = action_t'(in_tuser);

  // control state
  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] symbol_count_r, symbol_count_nxt;
  logic               table_valid_r, table_valid_nxt;
  logic               sampling_on_r, sampling_on_nxt;
  logic [COUNT_W-1:0] load_pos_r, load_pos_nxt;
  logic               load_pending_r, load_pending_nxt;
  logic               order_ok_r, order_ok_nxt;
  logic [CNT_AW-1:0]  clr_addr_r, clr_addr_nxt;
  logic               clr_resp_r, clr_resp_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;

  // datapath state
  logic [DATA_W-1:0]  last_sym_r, last_sym_nxt;
  logic [COUNT_W-1:0] lo_r, lo_nxt;
  logic [COUNT_W-1:0] hi_r, hi_nxt;
  logic [COUNT_W-1:0] mid_r, mid_nxt;
  logic [CNT_AW-1:0]  slot_r, slot_nxt;
  logic [DATA_W-1:0]  pc_r, pc_nxt;
  logic               rd_cnt_r, rd_cnt_nxt;
  logic [DATA_W-1:0]  res_data_r, res_data_nxt;
  err_t               res_err_r, res_err_nxt;
  logic [DATA_W-1:0]  out_data_r, out_data_nxt;
  err_t               out_err_r, out_err_nxt;

  // ram ports
  logic               sym_we, sym_re;
  logic [SYM_AW-1:0]  sym_waddr, sym_raddr;
  logic [DATA_W-1:0]  sym_wdata, sym_rdata;
  logic               cnt_we, cnt_re;
  logic [CNT_AW-1:0]  cnt_waddr, cnt_raddr;
  logic [DATA_W-1:0]  cnt_wdata, cnt_rdata;

  // shared search unit: midpoint adder and pc compare
  logic [COUNT_W:0]   mid_sum;
  logic [COUNT_W-1:0] mid_calc;
  logic               pc_ge;
  logic               accept;

  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_calc  = mid_sum[COUNT_W:1];
  assign pc_ge     = (pc_r >= sym_rdata);
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // sequencer
  always_comb begin
    logic               order_new;
    logic [COUNT_W-1:0] pos_inc;

    state_nxt        = state_r;
    symbol_count_nxt = symbol_count_r;
    table_valid_nxt  = table_valid_r;
    sampling_on_nxt  = sampling_on_r;
    load_pos_nxt     = load_pos_r;
    load_pending_nxt = load_pending_r;
    order_ok_nxt     = order_ok_r;
    clr_addr_nxt     = clr_addr_r;
    clr_resp_nxt     = clr_resp_r;
    last_sym_nxt     = last_sym_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    mid_nxt          = mid_r;
    slot_nxt         = slot_r;
    pc_nxt           = pc_r;
    rd_cnt_nxt       = rd_cnt_r;
    res_data_nxt     = res_data_r;
    res_err_nxt      = res_err_r;
    out_data_nxt     = out_data_r;
    out_err_nxt      = out_err_r;
    out_tvalid_nxt   = out_tvalid_r && !out_tready;

    sym_we    = 1'b0;
    sym_waddr = load_pos_r[SYM_AW-1:0];
    sym_wdata = symbol_value;
    sym_re    = 1'b0;
    sym_raddr = mid_calc[SYM_AW-1:0];
    cnt_we    = 1'b0;
    cnt_waddr = clr_addr_r;
    cnt_wdata = '0;
    cnt_re    = 1'b0;
    cnt_raddr = slot_r;

    order_new = order_ok_r;
    pos_inc   = load_pos_r + COUNT_W'(1);

    case (state_r)
      // counter sweep after reset or an accepted load_start
      S_CLEAR: begin
        cnt_we = 1'b1;
        if (clr_addr_r == CNT_AW'(CNT_DEPTH - 1)) begin
          state_nxt = clr_resp_r ? S_RESP : S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + CNT_AW'(1);
        end
      end

      // request decode
      S_IDLE: begin
        if (accept) begin
          res_data_nxt = '0;
          res_err_nxt  = ERR_OK;
          state_nxt    = S_RESP;
          case (action)
            ACT_LOAD_START: begin
              if (load_count > COUNT_W'(TABLE_DEPTH)) begin
                res_err_nxt = ERR_NO_SPACE;
              end else if (load_count < COUNT_W'(MIN_SYMBOLS)) begin
                res_err_nxt = ERR_TOO_SHORT;
              end else if (sampling_on_r) begin
                res_err_nxt = ERR_BUSY;
              end else begin
                symbol_count_nxt = load_count;
                table_valid_nxt  = 1'b0;
                load_pending_nxt = 1'b1;
                order_ok_nxt     = 1'b1;
                load_pos_nxt     = '0;
                clr_addr_nxt     = '0;
                clr_resp_nxt     = 1'b1;
                state_nxt        = S_CLEAR;
              end
            end
            ACT_LOAD_SYMBOL: begin
              if (!load_pending_r || load_pos_r >= symbol_count_r) begin
                res_err_nxt = ERR_BAD_REQUEST;
              end else begin
                if (load_pos_r != '0 && symbol_value < last_sym_r) begin
                  order_new = 1'b0;
                end
                order_ok_nxt = order_new;
                sym_we       = 1'b1;
                last_sym_nxt = symbol_value;
                load_pos_nxt = pos_inc;
                if (pos_inc == symbol_count_r) begin
                  load_pending_nxt = 1'b0;
                  table_valid_nxt  = order_new;
                  if (!order_new) begin
                    res_err_nxt = ERR_UNSORTED;
                  end
                end
              end
            end
            ACT_SAMPLE: begin
              if (sampling_on_r) begin
                if (user_mode) begin
                  slot_nxt  = CNT_AW'(symbol_count_r);
                  state_nxt = S_CNT_RD;
                end else begin
                  lo_nxt    = '0;
                  hi_nxt    = symbol_count_r;
                  pc_nxt    = sample_pc;
                  state_nxt = S_SRCH;
                end
              end
            end
            ACT_SET_ENABLE: begin
              if (table_valid_r) begin
                sampling_on_nxt = enable_request;
              end else begin
                res_err_nxt = ERR_NOT_LOADED;
              end
            end
            ACT_READ_STATUS: begin
              res_data_nxt = {{(DATA_W-2){1'b0}}, table_valid_r, sampling_on_r};
            end
            ACT_READ_COUNT: begin
              res_data_nxt = DATA_W'(symbol_count_r);
            end
            ACT_READ_SYMBOL: begin
              if (!table_valid_r) begin
                res_err_nxt = ERR_NOT_LOADED;
              end else if (read_index >= symbol_count_r) begin
                res_err_nxt = ERR_BAD_REQUEST;
              end else begin
                sym_re     = 1'b1;
                sym_raddr  = read_index[SYM_AW-1:0];
                rd_cnt_nxt = 1'b0;
                state_nxt  = S_RD_WAIT;
              end
            end
            ACT_READ_COUNTER: begin
              if (!table_valid_r) begin
                res_err_nxt = ERR_NOT_LOADED;
              end else if (read_index > symbol_count_r) begin
                res_err_nxt = ERR_BAD_REQUEST;
              end else begin
                cnt_re     = 1'b1;
                cnt_raddr  = CNT_AW'(read_index);
                rd_cnt_nxt = 1'b1;
                state_nxt  = S_RD_WAIT;
              end
            end
            default: begin
              res_err_nxt = ERR_BAD_REQUEST;
            end
          endcase
        end
      end

      // search step: form midpoint and fetch its symbol, or end the search on the slot
      S_SRCH: begin
        if (mid_calc == lo_r) begin
          slot_nxt  = CNT_AW'(lo_r);
          state_nxt = S_CNT_RD;
        end else begin
          sym_re    = 1'b1;
          mid_nxt   = mid_calc;
          state_nxt = S_CMP;
        end
      end

      // search step: narrow the interval
      S_CMP: begin
        if (pc_ge) begin
          lo_nxt = mid_r;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_SRCH;
      end

      // counter read-modify-write
      S_CNT_RD: begin
        cnt_re    = 1'b1;
        state_nxt = S_CNT_WR;
      end

      S_CNT_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = slot_r;
        cnt_wdata = cnt_rdata + DATA_W'(1);
        state_nxt = S_RESP;
      end

      // readback data returns
      S_RD_WAIT: begin
        res_data_nxt = rd_cnt_r ? cnt_rdata : sym_rdata;
        state_nxt    = S_RESP;
      end

      // hand the result to the output register once it is free
      S_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = res_data_r;
          out_err_nxt    = res_err_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      symbol_count_r <= '0;
      table_valid_r  <= 1'b0;
      sampling_on_r  <= 1'b0;
      load_pos_r     <= '0;
      load_pending_r <= 1'b0;
      order_ok_r     <= 1'b1;
      clr_addr_r     <= '0;
      clr_resp_r     <= 1'b0;
      out_tvalid_r   <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      symbol_count_r <= symbol_count_nxt;
      table_valid_r  <= table_valid_nxt;
      sampling_on_r  <= sampling_on_nxt;
      load_pos_r     <= load_pos_nxt;
      load_pending_r <= load_pending_nxt;
      order_ok_r     <= order_ok_nxt;
      clr_addr_r     <= clr_addr_nxt;
      clr_resp_r     <= clr_resp_nxt;
      out_tvalid_r   <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    last_sym_r <= last_sym_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    slot_r     <= slot_nxt;
    pc_r       <= pc_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    res_data_r <= res_data_nxt;
    res_err_r  <= res_err_nxt;
    out_data_r <= out_data_nxt;
    out_err_r  <= out_err_nxt;
  end

  // symbol table
  pcshp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_sym_ram (
    .clk   (clk),
    .we    (sym_we),
    .waddr (sym_waddr),
    .wdata (sym_wdata),
    .re    (sym_re),
    .raddr (sym_raddr),
    .rdata (sym_rdata)
  );

  // hit counters, one per interval plus the user-mode bin
  pcshp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CNT_DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // result beat
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

  // sampling only runs over a complete, sorted table
  a_on_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    sampling_on_r |-> table_valid_r)
    else $error("sampling on without a valid table");

  // a load in progress never leaves the table marked valid
  a_pending_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    load_pending_r |-> !table_valid_r)
    else $error("table valid while a load is pending");

  // the search interval never collapses before the step ends
  a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> (lo_r < hi_r) && (hi_r <= symbol_count_r))
    else $error("search bounds out of order");

  // a counter increment only targets an in-range bin
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CNT_WR) |-> (slot_r <= CNT_AW'(symbol_count_r)))
    else $error("counter slot beyond symbol count");

  // the sweep never overruns the counter ram
  a_clear_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (clr_addr_r <= CNT_AW'(CNT_DEPTH - 1)))
    else $error("clear address beyond counter ram");

endmodule

// File: rtl/core/pcshp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcshp_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pcshp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: dv/pc_sample_histogram_profiler_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_sample_histogram_profiler_unit_tb: self-checking bench of the pc profiler
// Loads sorted and broken symbol tables, runs kernel and user samples through
// the binning search and reads back status, tables and hit counters. A local
// histogram model predicts every answer beat, which is checked in order while
// both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module pc_sample_histogram_profiler_unit_tb;
  import pcshp_pkg::*;

  // beats at the end of the run that go out with no idling on either side
  localparam int CALM_TAIL  = 120;
  localparam int RAND_ITEMS = 1600;

  typedef struct {
    action_t              act;
    logic [COUNT_W-1:0]   load_count;
    logic [DATA_W-1:0]    symbol_value;
    logic [DATA_W-1:0]    sample_pc;
    logic                 user_mode;
    logic                 enable_request;
    logic [COUNT_W-1:0]   read_index;
    bit                   hold;          // wait for all answers before sending
  } req_t;

  typedef struct {
    logic [DATA_W-1:0] read_data;
    err_t              error_code;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [KIND_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [KIND_W-1:0] out_tuser;

  // stimulus and expectation stores
  req_t    req_q[$];
  answer_t answer_q[$];
  req_t    cur_req;
  int      gap_left = 0;
  int      stall_left = 0;
  int      fails = 0;
  int      countable = 0;
  bit      want_drain = 1'b0;
  logic [DATA_W-1:0] plan_syms[$];

  // histogram model state
  logic [DATA_W-1:0] sym_tab [TABLE_DEPTH];
  logic [DATA_W-1:0] hit_tab [CNT_DEPTH];
  int unsigned n_syms = 0;
  int unsigned ld_pos = 0;
  bit tab_ok = 1'b0;
  bit prof_on = 1'b0;
  bit ld_busy = 1'b0;
  bit ld_sorted = 1'b1;

  pc_sample_histogram_profiler_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // expected answer of one accepted request, updating the histogram model
  function automatic answer_t predict_answer(req_t r);
    answer_t a;
    int unsigned lo, hi, mid, slot;
    bit found;
    a.read_data = '0;
    a.error_code = ERR_OK;
    case (r.act)
      ACT_LOAD_START: begin
        if (r.load_count > TABLE_DEPTH) a.error_code = ERR_NO_SPACE;
        else if (r.load_count < MIN_SYMBOLS) a.error_code = ERR_TOO_SHORT;
        else if (prof_on) a.error_code = ERR_BUSY;
        else begin
          foreach (hit_tab[i]) hit_tab[i] = '0;
          n_syms = r.load_count;
          tab_ok = 1'b0;
          ld_busy = 1'b1;
          ld_sorted = 1'b1;
          ld_pos = 0;
        end
      end
      ACT_LOAD_SYMBOL: begin
        if (!ld_busy || ld_pos >= n_syms || ld_pos >= TABLE_DEPTH) begin
          a.error_code = ERR_BAD_REQUEST;
        end else begin
          if (ld_pos > 0 && r.symbol_value < sym_tab[ld_pos-1]) ld_sorted = 1'b0;
          sym_tab[ld_pos] = r.symbol_value;
          ld_pos++;
          if (ld_pos == n_syms) begin
            ld_busy = 1'b0;
            tab_ok = ld_sorted;
            if (!ld_sorted) a.error_code = ERR_UNSORTED;
          end
        end
      end
      ACT_SAMPLE: begin
        if (prof_on) begin
          if (r.user_mode) slot = n_syms;
          else begin
            // interval whose start is at or below the pc
            lo = 0;
            hi = n_syms;
            found = 1'b0;
            while (!found) begin
              mid = (lo + hi) / 2;
              if (mid == lo || mid >= TABLE_DEPTH) found = 1'b1;
              else if (r.sample_pc >= sym_tab[mid]) lo = mid;
              else hi = mid;
            end
            slot = lo;
          end
          if (slot <= TABLE_DEPTH) hit_tab[slot] = hit_tab[slot] + 1'b1;
        end
      end
      ACT_SET_ENABLE: begin
        if (tab_ok) prof_on = r.enable_request;
        else a.error_code = ERR_NOT_LOADED;
      end
      ACT_READ_STATUS: a.read_data = {30'd0, tab_ok, prof_on};
      ACT_READ_COUNT: a.read_data = n_syms;
      ACT_READ_SYMBOL: begin
        if (!tab_ok) a.error_code = ERR_NOT_LOADED;
        else if (r.read_index >= n_syms || r.read_index >= TABLE_DEPTH) begin
          a.error_code = ERR_BAD_REQUEST;
        end else a.read_data = sym_tab[r.read_index];
      end
      default: begin
        if (!tab_ok) a.error_code = ERR_NOT_LOADED;
        else if (r.read_index > n_syms || r.read_index > TABLE_DEPTH) begin
          a.error_code = ERR_BAD_REQUEST;
        end else a.read_data = hit_tab[r.read_index];
      end
    endcase
    return a;
  endfunction

  // queue one request; fields the action does not use carry random values
  task automatic push_req(action_t act, logic [31:0] arg, logic flag);
    req_t r;
    r.act = act;
    r.load_count = COUNT_W'($urandom);
    r.symbol_value = $urandom;
    r.sample_pc = $urandom;
    r.user_mode = $urandom_range(0, 1);
    r.enable_request = $urandom_range(0, 1);
    r.read_index = COUNT_W'($urandom);
    r.hold = want_drain;
    want_drain = 1'b0;
    case (act)
      ACT_LOAD_START: r.load_count = arg[COUNT_W-1:0];
      ACT_LOAD_SYMBOL: r.symbol_value = arg;
      ACT_SAMPLE: begin
        r.sample_pc = arg;
        r.user_mode = flag;
      end
      ACT_SET_ENABLE: r.enable_request = flag;
      ACT_READ_SYMBOL, ACT_READ_COUNTER: r.read_index = arg[COUNT_W-1:0];
      default: ;
    endcase
    req_q.push_back(r);
    countable++;
  endtask

  // one profiling run: load, optionally enable, sample and read, with refused and broken requests mixed in
  task automatic run_session(int n, bit go, int acts);
    logic [31:0] v;
    logic [31:0] pc;
    int bad_at, cut_at, i, k;
    plan_syms.delete();
    for (i = 0; i < n; i++) plan_syms.push_back($urandom);
    plan_syms.sort();
    if ($urandom_range(0, 3) == 0) begin
      i = $urandom_range(1, n - 1);
      plan_syms[i] = plan_syms[i-1];
    end
    bad_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n - 1) : -1;
    cut_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
    if ($urandom_range(0, 7) == 0) want_drain = 1'b1;
    push_req(ACT_SET_ENABLE, 0, 1'b0);
    // abandoned load, restarted by the next load_start
    if (cut_at >= 0) begin
      push_req(ACT_LOAD_START, n, 1'b0);
      for (i = 0; i < cut_at; i++) push_req(ACT_LOAD_SYMBOL, plan_syms[i], 1'b0);
    end
    push_req(ACT_LOAD_START, n, 1'b0);
    for (i = 0; i < n; i++) begin
      v = plan_syms[i];
      if (i == bad_at && plan_syms[i-1] != 0) v = $urandom_range(0, plan_syms[i-1] - 1);
      push_req(ACT_LOAD_SYMBOL, v, 1'b0);
    end
    push_req(ACT_SET_ENABLE, 0, go);
    for (k = 0; k < acts; k++) begin
      i = $urandom_range(0, n - 1);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
          case ($urandom_range(0, 5))
            0: pc = plan_syms[i];
            1: pc = plan_syms[i] - 1;
            2: pc = plan_syms[i] + 1;
            3: pc = '0;
            4: pc = '1;
            default: pc = $urandom;
          endcase
          push_req(ACT_SAMPLE, pc, $urandom_range(0, 4) == 0);
        end
        12, 13: push_req(ACT_READ_COUNTER, $urandom_range(0, n), 1'b0);
        14: push_req($urandom_range(0, 1) ? ACT_READ_COUNTER : ACT_READ_SYMBOL,
                     $urandom_range(0, 4095), 1'b0);
        15: push_req(ACT_READ_SYMBOL, i, 1'b0);
        16: push_req($urandom_range(0, 1) ? ACT_READ_STATUS : ACT_READ_COUNT, 0, 1'b0);
        17: begin
          // refused load_start: wrong size, or busy while sampling
          case ($urandom_range(0, 2))
            0: v = $urandom_range(0, 2);
            1: v = $urandom_range(TABLE_DEPTH + 1, 4095);
            default: v = go ? $urandom_range(MIN_SYMBOLS, TABLE_DEPTH) : 4095;
          endcase
          push_req(ACT_LOAD_START, v, 1'b0);
        end
        18: push_req(ACT_LOAD_SYMBOL, $urandom, 1'b0);
        default: push_req(ACT_SET_ENABLE, 0, go);
      endcase
    end
    if (n <= 16 && $urandom_range(0, 1)) begin
      for (i = 0; i <= n; i++) push_req(ACT_READ_COUNTER, i, 1'b0);
    end
    if ($urandom_range(0, 1)) push_req(ACT_SET_ENABLE, 0, 1'b0);
  endtask

  // driver: present queued beats, predict each one on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) answer_q.push_back(predict_answer(cur_req));
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (req_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (req_q[0].hold && answer_q.size() != 0) begin
          in_tvalid <= 1'b0;
        end else if (req_q.size() > CALM_TAIL && $urandom_range(0, 6) == 0) begin
          gap_left = $urandom_range(0, 3);
          in_tvalid <= 1'b0;
        end else begin
          cur_req = req_q.pop_front();
          in_tvalid <= 1'b1;
          // load_count, symbol_value, sample_pc, user_mode, enable_request,
          // read_index from the lowest bit up, zero fill above
          in_tdata <= IN_TDATA_W'({cur_req.read_index, cur_req.enable_request,
                                   cur_req.user_mode, cur_req.sample_pc,
                                   cur_req.symbol_value, cur_req.load_count});
          in_tuser <= cur_req.act;
        end
      end
    end
  end

  // monitor: check answer beats in order, stall the result side at random
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (answer_q.size() == 0) begin
          $error("unexpected answer beat: read_data %h error_code %0d", out_tdata, out_tuser);
          fails++;
        end else begin
          want = answer_q.pop_front();
          if (out_tdata !== want.read_data) begin
            $error("read_data mismatch: expected %h, actual %h", want.read_data, out_tdata);
            fails++;
          end
          if (out_tuser !== want.error_code) begin
            $error("error_code mismatch: expected %0d, actual %0d",
                   want.error_code, out_tuser);
            fails++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (req_q.size() > CALM_TAIL && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int mark;
    int j, burst;
    action_t act;
    foreach (sym_tab[i]) sym_tab[i] = '0;
    foreach (hit_tab[i]) hit_tab[i] = '0;

    // nothing loaded yet
    push_req(ACT_READ_STATUS, 0, 1'b0);
    push_req(ACT_READ_COUNT, 0, 1'b0);
    push_req(ACT_READ_SYMBOL, 0, 1'b0);
    push_req(ACT_READ_COUNTER, 0, 1'b0);
    push_req(ACT_SET_ENABLE, 0, 1'b1);
    push_req(ACT_SAMPLE, 32'h1234, 1'b0);
    push_req(ACT_LOAD_SYMBOL, 32'h10, 1'b0);
    // refused sizes
    push_req(ACT_LOAD_START, 4095, 1'b0);
    push_req(ACT_LOAD_START, TABLE_DEPTH + 1, 1'b0);
    push_req(ACT_LOAD_START, 0, 1'b0);
    push_req(ACT_LOAD_START, MIN_SYMBOLS - 1, 1'b0);
    // out-of-order table
    push_req(ACT_LOAD_START, MIN_SYMBOLS, 1'b0);
    push_req(ACT_LOAD_SYMBOL, 32'h100, 1'b0);
    push_req(ACT_LOAD_SYMBOL, 32'h50, 1'b0);
    push_req(ACT_LOAD_SYMBOL, 32'h200, 1'b0);
    push_req(ACT_SET_ENABLE, 0, 1'b1);
    // sorted table with an equal pair, top symbol at the address limit
    push_req(ACT_LOAD_START, MIN_SYMBOLS, 1'b0);
    push_req(ACT_LOAD_SYMBOL, 32'h1000, 1'b0);
    push_req(ACT_LOAD_SYMBOL, 32'h1000, 1'b0);
    push_req(ACT_LOAD_SYMBOL, 32'hFFFF_FFFF, 1'b0);
    push_req(ACT_LOAD_SYMBOL, 32'h0, 1'b0);
    push_req(ACT_SET_ENABLE, 0, 1'b1);
    push_req(ACT_LOAD_START, 5, 1'b0);
    // pc below the first symbol, at the top, and a user sample
    push_req(ACT_SAMPLE, 32'h0, 1'b0);
    push_req(ACT_SAMPLE, 32'hFFFF_FFFF, 1'b0);
    push_req(ACT_SAMPLE, 32'h1000, 1'b1);
    push_req(ACT_READ_COUNTER, MIN_SYMBOLS, 1'b0);
    push_req(ACT_READ_COUNTER, MIN_SYMBOLS + 1, 1'b0);
    push_req(ACT_READ_SYMBOL, MIN_SYMBOLS, 1'b0);
    push_req(ACT_READ_STATUS, 0, 1'b0);

    // random profiling runs with noise beats in between
    want_drain = 1'b1;
    countable = 0;
    while (countable < RAND_ITEMS) begin
      if (countable > RAND_ITEMS / 2 && mark == 0) begin
        // largest table size, left open and restarted by a later load
        mark = countable;
        push_req(ACT_SET_ENABLE, 0, 1'b0);
        push_req(ACT_LOAD_START, TABLE_DEPTH, 1'b0);
        push_req(ACT_READ_COUNT, 0, 1'b0);
        push_req(ACT_READ_STATUS, 0, 1'b0);
        push_req(ACT_LOAD_SYMBOL, 32'h0, 1'b0);
        push_req(ACT_READ_COUNTER, TABLE_DEPTH, 1'b0);
        push_req(ACT_READ_SYMBOL, TABLE_DEPTH - 1, 1'b0);
      end else if ($urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 5);
        for (j = 0; j < burst; j++) begin
          act = action_t'($urandom_range(0, 7));
          push_req(act, $urandom, $urandom_range(0, 1));
        end
      end else if ($urandom_range(0, 4) == 0) begin
        run_session($urandom_range(13, 100), $urandom_range(0, 4) != 0, $urandom_range(10, 40));
      end else begin
        run_session($urandom_range(MIN_SYMBOLS, 12), $urandom_range(0, 4) != 0,
                    $urandom_range(10, 40));
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (req_q.size() != 0 || in_tvalid || answer_q.size() != 0);
    repeat (60) @(posedge clk);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #30_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
